@@ rtl/core/tmcw_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tmcw_pkg
// Shared types and constants for the text mode console writer: operation
// codes, character codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package tmcw_pkg;

    // default screen geometry
    localparam int DEF_COLUMNS    = 80;
    localparam int DEF_ROWS       = 25;
    localparam int DEF_TAB_SPACES = 4;

    // fixed field widths
    localparam int OP_W    = 2;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int INDEX_W = 11;
    localparam int POS_W   = 11;
    localparam int CELL_W  = 16;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 32;

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_RETURN  = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;

    // space, light grey on black
    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_PUT,
        ST_COPY,
        ST_COPY_END,
        ST_BLANK,
        ST_READ_DATA,
        ST_FILL,
        ST_RESULT
    } state_t;

    // cursor update
    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_ADVANCE,
        CUR_NEWLINE,
        CUR_RETURN,
        CUR_HOME
    } cur_op_t;

    // cell store access
    typedef enum logic [2:0] {
        MEM_NONE,
        MEM_PUT,
        MEM_FILL_INIT,
        MEM_FILL_CLEAR,
        MEM_COPY,
        MEM_BLANK,
        MEM_READ
    } mem_op_t;

    // sweep address counter
    typedef enum logic [1:0] {
        SW_HOLD,
        SW_ZERO,
        SW_BLANK_BASE,
        SW_INC
    } sweep_op_t;

    typedef struct packed {
        logic      load_item;
        cur_op_t   cur_op;
        mem_op_t   mem_op;
        sweep_op_t sweep_op;
        logic      tab_dec;
        logic      set_scrolled;
        logic      capture_value;
        logic      load_result;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            is_newline;
        logic            is_return;
        logic            col_last;
        logic            row_last;
        logic            copy_end;
        logic            sweep_end;
        logic            tab_one;
        logic            tab_zero;
        logic            out_free;
    } status_t;

endpackage : tmcw_pkg
`default_nettype wire

@@ rtl/core/tmcw_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tmcw_ctrl
// Controller state machine: sequences init fill, puts, tab repeats, scroll
// copy and blank, clear fill, reads and the result handoff.
// ----------------------------------------------------------------------------
module tmcw_ctrl
    import tmcw_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire status_t sts,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_INIT: begin
                cmd.mem_op   = MEM_FILL_INIT;
                cmd.sweep_op = SW_INC;
                if (sts.sweep_end) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (sts.op)
                    OP_PUT: begin
                        if (sts.is_newline) begin
                            // no glyph left to put once the scroll is done
                            cmd.cur_op  = CUR_NEWLINE;
                            cmd.tab_dec = 1'b1;
                            if (sts.row_last) begin
                                cmd.set_scrolled = 1'b1;
                                cmd.sweep_op     = SW_ZERO;
                                state_next       = ST_COPY;
                            end else begin
                                state_next = ST_RESULT;
                            end
                        end else if (sts.is_return) begin
                            cmd.cur_op = CUR_RETURN;
                            state_next = ST_RESULT;
                        end else begin
                            state_next = ST_PUT;
                        end
                    end
                    OP_CLEAR: begin
                        cmd.sweep_op = SW_ZERO;
                        state_next   = ST_FILL;
                    end
                    OP_READ: begin
                        cmd.mem_op = MEM_READ;
                        state_next = ST_READ_DATA;
                    end
                    default: begin
                        state_next = ST_RESULT;
                    end
                endcase
            end
            ST_PUT: begin
                cmd.mem_op  = MEM_PUT;
                cmd.cur_op  = CUR_ADVANCE;
                cmd.tab_dec = 1'b1;
                if (sts.col_last && sts.row_last) begin
                    cmd.set_scrolled = 1'b1;
                    cmd.sweep_op     = SW_ZERO;
                    state_next       = ST_COPY;
                end else if (sts.tab_one) begin
                    state_next = ST_RESULT;
                end
            end
            ST_COPY: begin
                cmd.mem_op   = MEM_COPY;
                cmd.sweep_op = SW_INC;
                if (sts.copy_end) begin
                    state_next = ST_COPY_END;
                end
            end
            ST_COPY_END: begin
                // last copy write drains here
                cmd.sweep_op = SW_BLANK_BASE;
                state_next   = ST_BLANK;
            end
            ST_BLANK: begin
                cmd.mem_op   = MEM_BLANK;
                cmd.sweep_op = SW_INC;
                if (sts.sweep_end) begin
                    state_next = sts.tab_zero ? ST_RESULT : ST_PUT;
                end
            end
            ST_READ_DATA: begin
                cmd.capture_value = 1'b1;
                state_next        = ST_RESULT;
            end
            ST_FILL: begin
                cmd.mem_op   = MEM_FILL_CLEAR;
                cmd.sweep_op = SW_INC;
                if (sts.sweep_end) begin
                    cmd.cur_op = CUR_HOME;
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (sts.out_free) begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule : tmcw_ctrl
`default_nettype wire

@@ rtl/core/tmcw_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tmcw_datapath
// Cell store, cursor, sweep counter, tab counter, item capture and the
// result register.
// ----------------------------------------------------------------------------
module tmcw_datapath
    import tmcw_pkg::*;
#(
    parameter int COLUMNS    = DEF_COLUMNS,
    parameter int ROWS       = DEF_ROWS,
    parameter int TAB_SPACES = DEF_TAB_SPACES
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire cmd_t                cmd,
    output status_t                  sts,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic [OP_W-1:0]     s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int AW = $clog2(CELL_COUNT);
    localparam int RW = $clog2(ROWS);
    localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int TW = $clog2(TAB_SPACES + 1);
    localparam int XW = (AW > INDEX_W) ? AW : INDEX_W;

    // item fields
    logic [OP_W-1:0]    op_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic [ATTR_W-1:0]  attr_reg;
    logic [INDEX_W-1:0] index_reg;

    // cursor, counters
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [AW-1:0] sweep_reg;
    logic [AW-1:0] sweep_next;
    logic [TW-1:0] tab_reg;

    // copy pipeline
    logic          wr_pend_reg;
    logic [AW-1:0] wr_addr_reg;

    // result
    logic              out_valid_reg;
    logic [POS_W-1:0]  out_pos_reg;
    logic [CELL_W-1:0] out_value_reg;
    logic              out_scrolled_reg;
    logic [CELL_W-1:0] value_reg;
    logic              scrolled_reg;

    // cell store
    logic [CELL_W-1:0] mem [CELL_COUNT];
    logic [CELL_W-1:0] rd_data_reg;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [CELL_W-1:0] wr_data;

    logic [XW-1:0]     index_ext;
    logic [XW-1:0]     pos_ext;
    logic              index_ok;
    logic [CHAR_W-1:0] put_char;
    logic [CHAR_W-1:0] s_char;

    assign index_ext = XW'(index_reg);
    assign index_ok  = index_ext < XW'(CELL_COUNT);
    assign pos_ext   = XW'(row_reg) * XW'(COLUMNS) + XW'(col_reg);
    assign put_char  = (char_reg == CHAR_TAB) ? CHAR_SPACE : char_reg;
    assign s_char    = s_tdata[CHAR_W-1:0];

    // item capture
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg    <= s_tuser;
            char_reg  <= s_char;
            attr_reg  <= s_tdata[CHAR_W +: ATTR_W];
            index_reg <= s_tdata[CHAR_W+ATTR_W +: INDEX_W];
        end
    end

    // cursor update
    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        case (cmd.cur_op)
            CUR_ADVANCE: begin
                if (sts.col_last) begin
                    col_next = '0;
                    if (!sts.row_last) begin
                        row_next = row_reg + RW'(1);
                    end
                end else begin
                    col_next = col_reg + CW'(1);
                end
            end
            CUR_NEWLINE: begin
                col_next = '0;
                if (!sts.row_last) begin
                    row_next = row_reg + RW'(1);
                end
            end
            CUR_RETURN: begin
                col_next = '0;
            end
            CUR_HOME: begin
                col_next = '0;
                row_next = '0;
            end
            default: begin
                row_next = row_reg;
            end
        endcase
    end

    // sweep address
    always_comb begin
        case (cmd.sweep_op)
            SW_ZERO:       sweep_next = '0;
            SW_BLANK_BASE: sweep_next = AW'((ROWS - 1) * COLUMNS);
            SW_INC:        sweep_next = sweep_reg + AW'(1);
            default:       sweep_next = sweep_reg;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg       <= '0;
            col_reg       <= '0;
            sweep_reg     <= '0;
            tab_reg       <= '0;
            wr_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            row_reg     <= row_next;
            col_reg     <= col_next;
            sweep_reg   <= sweep_next;
            wr_pend_reg <= (cmd.mem_op == MEM_COPY);
            if (cmd.load_item) begin
                tab_reg <= (s_char == CHAR_TAB) ? TW'(TAB_SPACES) : TW'(1);
            end else if (cmd.tab_dec) begin
                tab_reg <= tab_reg - TW'(1);
            end
            if (cmd.load_result) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // per-item flags and result payload
    always_ff @(posedge aclk) begin
        wr_addr_reg <= sweep_reg;
        if (cmd.load_item) begin
            value_reg    <= '0;
            scrolled_reg <= 1'b0;
        end else begin
            if (cmd.set_scrolled) begin
                scrolled_reg <= 1'b1;
            end
            if (cmd.capture_value && index_ok) begin
                value_reg <= rd_data_reg;
            end
        end
        if (cmd.load_result) begin
            out_pos_reg      <= pos_ext[POS_W-1:0];
            out_value_reg    <= value_reg;
            out_scrolled_reg <= scrolled_reg;
        end
    end

    // store port selection, pending copy write first
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = sweep_reg;
        wr_data = {attr_reg, CHAR_SPACE};
        rd_addr = index_ext[AW-1:0];
        if (cmd.mem_op == MEM_COPY) begin
            rd_addr = sweep_reg + AW'(COLUMNS);
        end
        if (wr_pend_reg) begin
            wr_en   = 1'b1;
            wr_addr = wr_addr_reg;
            wr_data = rd_data_reg;
        end else begin
            case (cmd.mem_op)
                MEM_PUT: begin
                    wr_en   = 1'b1;
                    wr_addr = pos_ext[AW-1:0];
                    wr_data = {attr_reg, put_char};
                end
                MEM_FILL_INIT: begin
                    wr_en   = 1'b1;
                    wr_data = RESET_CELL;
                end
                MEM_FILL_CLEAR, MEM_BLANK: begin
                    wr_en = 1'b1;
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    // cell store
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // status to controller
    always_comb begin
        sts            = '0;
        sts.op         = op_reg;
        sts.is_newline = (char_reg == CHAR_NEWLINE);
        sts.is_return  = (char_reg == CHAR_RETURN);
        sts.col_last   = (col_reg == CW'(COLUMNS - 1));
        sts.row_last   = (row_reg == RW'(ROWS - 1));
        sts.copy_end   = (sweep_reg == AW'(CELL_COUNT - COLUMNS - 1));
        sts.sweep_end  = (sweep_reg == AW'(CELL_COUNT - 1));
        sts.tab_one    = (tab_reg == TW'(1));
        sts.tab_zero   = (tab_reg == '0);
        sts.out_free   = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'({out_scrolled_reg, out_value_reg, out_pos_reg});

endmodule : tmcw_datapath
`default_nettype wire

@@ rtl/core/text_mode_console_writer_unit.sv @@
`default_nettype none
// Each transfer gives one result; a tab puts TAB_SPACES spaces before its
//   result. A scroll copies the store up one row, then blanks the last row.
// Clear fills the store with spaces and homes the cursor. One item at a time,
//   next transfer taken in the cycle the result is offered.
// After reset a fill pass writes every cell to 0x0720;
//   s_tready stays low until it finishes. Cursor resets to row 0, column 0.
// ----------------------------------------------------------------------------
// text_mode_console_writer_unit
// Text console engine: puts characters with attributes, scrolls, clears the
// screen and reads back cells from a COLUMNS by ROWS cell store.
// ----------------------------------------------------------------------------
module text_mode_console_writer_unit
    import tmcw_pkg::*;
#(
    parameter int COLUMNS    = DEF_COLUMNS,
    parameter int ROWS       = DEF_ROWS,
    parameter int TAB_SPACES = DEF_TAB_SPACES
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // char_code[7:0], attribute[15:8], cell_index[26:16], zero fill
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // operation[1:0]
    input  wire logic [OP_W-1:0]     s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // cursor_position[10:0], cell_value[26:11], scrolled[27], zero fill
    output logic [M_DATA_W-1:0]      m_tdata
);

    cmd_t    cmd;
    status_t sts;

    // controller
    tmcw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    tmcw_datapath #(
        .COLUMNS    (COLUMNS),
        .ROWS       (ROWS),
        .TAB_SPACES (TAB_SPACES)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule : text_mode_console_writer_unit
`default_nettype wire

@@ tb/tb_text_mode_console_writer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_mode_console_writer_unit
// Self-checking bench for the text console writer. A behavioral model of the
// cell store and cursor predicts cursor position, read value and scroll flag
// for every accepted command; a monitor compares each result transfer in
// order. Directed checks cover power-on contents, control codes, the unused
// operation and clear; then line-structured random traffic drives wraps,
// scrolls, tabs and reads under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_text_mode_console_writer_unit;
    import tmcw_pkg::*;

    localparam int COLUMNS      = DEF_COLUMNS;
    localparam int ROWS         = DEF_ROWS;
    localparam int TAB_SPACES   = DEF_TAB_SPACES;
    localparam int CELLS        = COLUMNS * ROWS;
    localparam int INDEX_TOP    = (1 << INDEX_W) - 1;
    localparam int RANDOM_ITEMS = 1500;
    localparam int LONG_HOLD    = 400;
    localparam int IDLE_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 20;

    // operation code with no function in the block
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // white and yellow on black
    localparam logic [ATTR_W-1:0] ATTR_WHITE  = 8'h0F;
    localparam logic [ATTR_W-1:0] ATTR_YELLOW = 8'h0E;

    typedef struct packed {
        logic [POS_W-1:0]  cursor_position;
        logic [CELL_W-1:0] cell_value;
        logic              scrolled;
    } console_result_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [OP_W-1:0]     s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // console model state
    logic [CELL_W-1:0] screen_model [CELLS];
    int unsigned       cursor_row_model;
    int unsigned       cursor_col_model;

    console_result_t expected_results [$];

    int burst_left    = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int rx_cycle      = 0;
    int quiet_cycles  = 0;
    int fail_count    = 0;
    int items_sent    = 0;
    int put_count     = 0;
    int clear_count   = 0;
    int read_count    = 0;
    int unused_count  = 0;
    int scroll_count  = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    text_mode_console_writer_unit #(
        .COLUMNS    (COLUMNS),
        .ROWS       (ROWS),
        .TAB_SPACES (TAB_SPACES)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------------
    // console model
    // ------------------------------------------------------------------------

    // fill every cell and home the cursor
    function automatic void fill_model(input logic [CELL_W-1:0] fill_value);
        int i;
        for (i = 0; i < CELLS; i++) screen_model[i] = fill_value;
        cursor_row_model = 0;
        cursor_col_model = 0;
    endfunction

    // move to the start of the next row, scrolling past the bottom
    function automatic logic line_feed_model(input logic [ATTR_W-1:0] attr);
        int i;
        cursor_col_model = 0;
        cursor_row_model++;
        if (cursor_row_model >= ROWS) begin
            for (i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
            for (i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = {attr, CHAR_SPACE};
            cursor_row_model = ROWS - 1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // store one glyph at the cursor and advance with wrap
    function automatic logic glyph_model(input logic [CHAR_W-1:0] ch,
                                         input logic [ATTR_W-1:0] attr);
        screen_model[cursor_row_model * COLUMNS + cursor_col_model] = {attr, ch};
        cursor_col_model++;
        if (cursor_col_model >= COLUMNS) return line_feed_model(attr);
        return 1'b0;
    endfunction

    // apply one command to the model and return the status it produces
    function automatic console_result_t predict_console(input logic [OP_W-1:0]    op,
                                                        input logic [CHAR_W-1:0]  ch,
                                                        input logic [ATTR_W-1:0]  attr,
                                                        input logic [INDEX_W-1:0] idx);
        console_result_t res;
        int i;
        res = '0;
        case (op)
            OP_PUT: begin
                put_count++;
                if (ch == CHAR_NEWLINE) begin
                    res.scrolled = line_feed_model(attr);
                end else if (ch == CHAR_RETURN) begin
                    cursor_col_model = 0;
                end else if (ch == CHAR_TAB) begin
                    for (i = 0; i < TAB_SPACES; i++)
                        if (glyph_model(CHAR_SPACE, attr)) res.scrolled = 1'b1;
                end else begin
                    res.scrolled = glyph_model(ch, attr);
                end
            end
            OP_CLEAR: begin
                clear_count++;
                fill_model({attr, CHAR_SPACE});
            end
            OP_READ: begin
                read_count++;
                if (idx < CELLS) res.cell_value = screen_model[idx];
            end
            default: begin
                unused_count++;
            end
        endcase
        res.cursor_position = POS_W'(cursor_row_model * COLUMNS + cursor_col_model);
        if (res.scrolled) scroll_count++;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // command source
    // ------------------------------------------------------------------------

    // offer one command; bursts of back-to-back transfers with gaps between
    task automatic send_item(input logic [OP_W-1:0]    op,
                             input logic [CHAR_W-1:0]  ch,
                             input logic [ATTR_W-1:0]  attr,
                             input logic [INDEX_W-1:0] idx);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_DATA_W - CHAR_W - ATTR_W - INDEX_W){1'b0}}, idx, attr, ch};
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(predict_console(op, ch, attr, idx));
        items_sent++;
        burst_left--;
        if (burst_left == 0) s_tvalid <= 1'b0;
    endtask

    // drop valid when the stimulus pauses mid-burst
    task automatic end_stream();
        if (burst_left != 0) begin
            s_tvalid   <= 1'b0;
            burst_left = 0;
        end
    endtask

    // a run of characters, mostly printable, with an optional terminator
    task automatic send_text_line(input int                len,
                                  input logic [ATTR_W-1:0] attr,
                                  input bit                terminate,
                                  input logic [CHAR_W-1:0] ending);
        int n;
        logic [CHAR_W-1:0] ch;
        logic [ATTR_W-1:0] glyph_attr;
        for (n = 0; n < len; n++) begin
            if ($urandom_range(0, 9) == 0) ch = CHAR_W'($urandom_range(0, 255));
            else ch = CHAR_W'($urandom_range(8'h21, 8'h7E));
            glyph_attr = ($urandom_range(0, 7) == 0) ? ATTR_W'($urandom) : attr;
            send_item(OP_PUT, ch, glyph_attr, INDEX_W'($urandom));
        end
        if (terminate) send_item(OP_PUT, ending, attr, INDEX_W'($urandom));
    endtask

    // reads aimed at recent rows, anywhere, and past the end of the store
    task automatic send_reads(input int count);
        int n;
        int row;
        int pick;
        logic [INDEX_W-1:0] idx;
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                row = cursor_row_model;
                row -= $urandom_range(0, (row < 2) ? row : 2);
                idx = INDEX_W'(row * COLUMNS + $urandom_range(0, COLUMNS - 1));
            end else if (pick < 8) begin
                idx = INDEX_W'($urandom_range(0, CELLS - 1));
            end else begin
                idx = INDEX_W'($urandom_range(CELLS, INDEX_TOP));
            end
            send_item(OP_READ, CHAR_W'($urandom), ATTR_W'($urandom), idx);
        end
    endtask

    // ------------------------------------------------------------------------
    // result sink: stall pattern plus an on-demand long hold
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        rx_cycle++;
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case ((rx_cycle / 97) % 3)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ((rx_cycle % 5) < 2);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // result check against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        console_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transfer, m_tdata=%h", m_tdata);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[10:0] !== want.cursor_position) begin
                    $error("cursor_position expected %0d actual %0d",
                           want.cursor_position, m_tdata[10:0]);
                    fail_count++;
                end
                if (m_tdata[26:11] !== want.cell_value) begin
                    $error("cell_value expected %h actual %h", want.cell_value, m_tdata[26:11]);
                    fail_count++;
                end
                if (m_tdata[27] !== want.scrolled) begin
                    $error("scrolled expected %0b actual %0b", want.scrolled, m_tdata[27]);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("text_mode_console_writer_unit verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // store contents after the power-on fill, including reads past the end
    task automatic test_power_on_screen();
        send_item(OP_READ, '0, '0, '0);
        send_item(OP_READ, '1, '1, INDEX_W'(CELLS - 1));
        send_item(OP_READ, '0, '0, INDEX_W'(CELLS));
        send_item(OP_READ, '1, '1, INDEX_W'(INDEX_TOP));
    endtask

    // plain glyphs at the byte extremes, control codes and the unused code
    task automatic test_put_codes();
        send_item(OP_PUT, 8'h41, ATTR_WHITE, '0);
        send_item(OP_PUT, 8'h00, 8'h00, '1);
        send_item(OP_PUT, 8'hFF, 8'hFF, '0);
        send_item(OP_READ, '0, '0, INDEX_W'(0));
        send_item(OP_READ, '0, '0, INDEX_W'(1));
        send_item(OP_READ, '0, '0, INDEX_W'(2));
        send_item(OP_PUT, CHAR_RETURN, ATTR_WHITE, '0);
        send_item(OP_PUT, CHAR_TAB, ATTR_YELLOW, '0);
        send_item(OP_READ, '0, '0, INDEX_W'(TAB_SPACES - 1));
        send_item(OP_PUT, CHAR_NEWLINE, ATTR_WHITE, '0);
        send_item(OP_UNUSED, '1, '1, '1);
        send_item(OP_UNUSED, '0, '0, '0);
    endtask

    // clear with a colored blank, then sample both ends of the store
    task automatic test_clear_screen();
        send_item(OP_CLEAR, 8'h41, 8'h1E, '0);
        send_item(OP_READ, '0, '0, INDEX_W'(0));
        send_item(OP_READ, '0, '0, INDEX_W'(CELLS - 1));
    endtask

    // lines down past the bottom: newline scroll, wrap scroll, tab across the end
    task automatic test_scroll_and_wrap();
        int line;
        logic [ATTR_W-1:0] attr;
        send_item(OP_CLEAR, CHAR_W'($urandom), ATTR_W'($urandom), INDEX_W'($urandom));
        for (line = 0; line < ROWS + 3; line++) begin
            attr = ATTR_W'($urandom);
            if (line == ROWS + 1) send_text_line(COLUMNS, attr, 1'b0, CHAR_NEWLINE);
            else if (line == ROWS + 2) send_text_line(COLUMNS - 2, attr, 1'b1, CHAR_TAB);
            else send_text_line($urandom_range(0, 20), attr, 1'b1, CHAR_NEWLINE);
        end
        send_reads(8);
    endtask

    // sink holds off while commands keep coming, so the block stalls its input
    task automatic test_receiver_backpressure();
        hold_request = LONG_HOLD;
        send_text_line(12, ATTR_W'($urandom), 1'b1, CHAR_NEWLINE);
        send_reads(4);
    endtask

    // mostly text lines and reads, with tabs, clears and raw noise mixed in
    task automatic test_random_traffic();
        int start;
        int kind;
        int r;
        logic [OP_W-1:0] op;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                r = $urandom_range(0, 9);
                send_text_line(($urandom_range(0, 5) == 0) ? $urandom_range(60, 170)
                                                           : $urandom_range(0, 30),
                               ATTR_W'($urandom), (r < 9),
                               (r < 7) ? CHAR_NEWLINE : CHAR_RETURN);
            end else if (kind < 60) begin
                send_reads($urandom_range(1, 8));
            end else if (kind < 70) begin
                repeat ($urandom_range(1, 6))
                    send_item(OP_PUT, CHAR_TAB, ATTR_W'($urandom), INDEX_W'($urandom));
            end else if (kind < 90) begin
                repeat ($urandom_range(1, 5)) begin
                    op = OP_W'($urandom_range(0, 3));
                    if (op == OP_CLEAR && $urandom_range(0, 7) != 0) op = OP_UNUSED;
                    send_item(op, CHAR_W'($urandom), ATTR_W'($urandom), INDEX_W'($urandom));
                end
            end else if (kind < 93) begin
                send_item(OP_CLEAR, CHAR_W'($urandom), ATTR_W'($urandom), INDEX_W'($urandom));
            end else begin
                repeat ($urandom_range(1, 5))
                    send_item(OP_PUT, CHAR_NEWLINE, ATTR_W'($urandom), INDEX_W'($urandom));
            end
        end
    endtask

    initial begin
        fill_model(RESET_CELL);
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_power_on_screen();
        test_put_codes();
        test_clear_screen();
        test_scroll_and_wrap();
        test_receiver_backpressure();
        test_random_traffic();
        end_stream();

        // let the last results drain
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d commands: %0d puts, %0d clears, %0d reads, %0d unused",
                 items_sent, put_count, clear_count, read_count, unused_count);
        $display("%0d commands scrolled the screen; sink held off %0d cycles once",
                 scroll_count, LONG_HOLD);
        if (fail_count == 0) begin
            $display("text_mode_console_writer_unit verification clean");
        end else begin
            $display("text_mode_console_writer_unit verification failed");
        end
        $finish;
    end

endmodule
